[design/scat_pkg.sv]
// ----------------------------------------------------------------------------
// scat_pkg: shared types and constants
// widths, config indexes, register reset values and shared-unit operation codes
// ----------------------------------------------------------------------------
package scat_pkg;

  localparam int unsigned MaxIterations = 32;
  localparam int unsigned IterW = $clog2(MaxIterations + 1);

  localparam int unsigned CoordW = 32;
  localparam int unsigned ExtW   = 31;
  localparam int unsigned TimeW  = 31;
  localparam int unsigned TolW   = 16;
  localparam int unsigned CfgW   = 31;
  localparam int unsigned CfgIdxW = 2;

  // wide datapath: squares of 50-bit magnitudes summed over three axes
  localparam int unsigned WideW = 104;
  localparam int unsigned RootW = 52;

  localparam logic [CfgIdxW-1:0] CfgTimeStep = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTolerance = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSpeedEps = 2'd2;

  localparam logic [TimeW-1:0] TimeStepReset = 31'd1092;
  localparam logic [TolW-1:0]  ToleranceReset = 16'd66;
  localparam logic [TolW-1:0]  SpeedEpsReset = 16'd1;

  typedef enum logic [1:0] {
    OP_SQRT = 2'd0,
    OP_DIV  = 2'd1
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

[design/scat_unit.sv]
// ----------------------------------------------------------------------------
// scat_unit: shared iterative square root / divider
// one result bit per cycle: restoring square root or restoring division
// ----------------------------------------------------------------------------
module scat_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  scat_pkg::unit_ctl_t           ctl,
  input  logic [scat_pkg::WideW-1:0]    opa,
  input  logic [scat_pkg::WideW-1:0]    opb,
  output scat_pkg::unit_sts_t           sts,
  output logic [scat_pkg::WideW-1:0]    result
);
  import scat_pkg::*;

  localparam int unsigned CntW = $clog2(WideW + 1);
  localparam int unsigned RemW = WideW + 2;

  logic              busy;
  logic              done;
  unit_op_t          op;
  logic [CntW-1:0]   cnt;
  logic [WideW-1:0]  num;
  logic [WideW-1:0]  den;
  logic [RemW-1:0]   rem;
  logic [WideW-1:0]  quo;

  logic [RemW-1:0]   rem_sh;
  logic [RemW-1:0]   trial;
  logic              take;

  always_comb begin
    if (op == OP_SQRT) begin
      rem_sh = {rem[RemW-3:0], num[WideW-1:WideW-2]};
      trial  = {quo[RemW-3:0], 2'b01};
    end else begin
      rem_sh = {rem[RemW-2:0], num[WideW-1]};
      trial  = {2'b00, den};
    end
    take = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start && !busy) begin
        busy <= 1'b1;
        op   <= ctl.op;
        num  <= opa;
        den  <= opb;
        rem  <= '0;
        quo  <= '0;
        cnt  <= (ctl.op == OP_SQRT) ? CntW'(WideW / 2) : CntW'(WideW);
      end else if (busy) begin
        rem <= take ? rem_sh - trial : rem_sh;
        quo <= {quo[WideW-2:0], take};
        num <= (op == OP_SQRT) ? {num[WideW-3:0], 2'b00} : {num[WideW-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign result   = quo;

endmodule

[design/sphere_conservative_advancement_toi_unit.sv]
// ----------------------------------------------------------------------------
// sphere_conservative_advancement_toi_unit: sphere-bounded time of impact
// conservative advancement of two box-bounded spheres in Q16.16
// ----------------------------------------------------------------------------
// One beat in gives one beat out. The block takes an item, then is busy until
// its result beat is taken. Each radius costs one square root plus a sum of
// squares and its launch. A full advancement round costs a root, a division
// for the closing speed and a division for the time increment, on top of the
// position, partial-product multiply/accumulate (five per axis), launch and
// test steps. All roots and divides run on one shared bit-serial root/divide
// unit, which works out one result bit per cycle. An item takes at most 32 rounds.
// ----------------------------------------------------------------------------
module sphere_conservative_advancement_toi_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [scat_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [scat_pkg::CfgW-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [scat_pkg::CoordW-1:0] offset_x,
  input  logic signed [scat_pkg::CoordW-1:0] offset_y,
  input  logic signed [scat_pkg::CoordW-1:0] offset_z,
  input  logic signed [scat_pkg::CoordW-1:0] rel_vel_x,
  input  logic signed [scat_pkg::CoordW-1:0] rel_vel_y,
  input  logic signed [scat_pkg::CoordW-1:0] rel_vel_z,
  input  logic [scat_pkg::ExtW-1:0]         extent_a_x,
  input  logic [scat_pkg::ExtW-1:0]         extent_a_y,
  input  logic [scat_pkg::ExtW-1:0]         extent_a_z,
  input  logic [scat_pkg::ExtW-1:0]         extent_b_x,
  input  logic [scat_pkg::ExtW-1:0]         extent_b_y,
  input  logic [scat_pkg::ExtW-1:0]         extent_b_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              hit,
  output logic [scat_pkg::TimeW-1:0]        impact_time
);
  import scat_pkg::*;

  // sequencer: explicit one-hot states
  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_RSQ    = 14'b00000000000010, // sum of squares of one extent vector
    S_RROOT  = 14'b00000000000100, // wait for radius root
    S_POS    = 14'b00000000001000, // offset at t, one axis per cycle
    S_MUL    = 14'b00000000010000, // partial products, five per axis
    S_LROOT  = 14'b00000000100000, // wait for length root
    S_CHECK  = 14'b00000001000000, // hit / separating tests
    S_CDIV   = 14'b00000010000000, // closing speed division
    S_CTEST  = 14'b00000100000000,
    S_TDIV   = 14'b00001000000000, // time increment division
    S_TTEST  = 14'b00010000000000,
    S_OUT    = 14'b00100000000000,
    S_START  = 14'b01000000000000, // launch shared unit
    S_SPARE  = 14'b10000000000000
  } state_t;

  // partial-product step within one axis
  typedef enum logic [4:0] {
    MP_LOLO = 5'b00001,
    MP_HILO = 5'b00010,
    MP_HIHI = 5'b00100,
    MP_LOV  = 5'b01000,
    MP_HIV  = 5'b10000
  } mac_phase_t;

  localparam int unsigned PosW = 50;   // offset at t fits 49 bits signed
  localparam int unsigned MagW = PosW;
  localparam int unsigned HalfW = MagW / 2;

  state_t state, ret_state;
  mac_phase_t mphase;

  logic [TimeW-1:0] time_step;
  logic [TolW-1:0]  tolerance;
  logic [TolW-1:0]  speed_eps;

  logic signed [CoordW-1:0] off [3];
  logic signed [CoordW-1:0] vel [3];
  logic [ExtW-1:0]          ext [6];

  logic [1:0]             axis;
  logic                   which_box;   // 0 box a, 1 box b
  logic [IterW-1:0]       iter;
  logic [TimeW-1:0]       t;
  logic [RootW:0]         comb;
  logic [MagW-1:0]        pmag [3];
  logic [2:0]             pneg;
  logic [WideW-1:0]       sq;
  logic [WideW-1:0]       pos_acc;
  logic [WideW-1:0]       neg_acc;
  logic [RootW-1:0]       len;
  logic [WideW-1:0]       closing;

  logic                   res_hit;
  logic [TimeW-1:0]       res_time;

  unit_ctl_t              uctl;
  unit_sts_t              usts;
  logic [WideW-1:0]       uopa;
  logic [WideW-1:0]       uopb;
  logic [WideW-1:0]       ures;

  scat_unit u_unit (
    .clk    (clk),
    .rst    (rst),
    .ctl    (uctl),
    .opa    (uopa),
    .opb    (uopb),
    .sts    (usts),
    .result (ures)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= TimeStepReset;
      tolerance <= ToleranceReset;
      speed_eps <= SpeedEpsReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgTimeStep:  time_step <= cfg_data[TimeW-1:0];
        CfgTolerance: tolerance <= cfg_data[TolW-1:0];
        CfgSpeedEps:  speed_eps <= cfg_data[TolW-1:0];
        default: ;
      endcase
    end
  end

  // position arithmetic: vel * t is one 32x31 multiply, floored by >>> 16
  logic signed [63:0]      vt;
  logic signed [PosW-1:0]  o_at_t;
  logic [CoordW-1:0]       vmag;
  logic [ExtW-1:0]         e_cur;
  logic [2*ExtW-1:0]       e_sq;
  logic [2:0]              ext_sel;

  // one 25x32 multiplier walks the partial products of |o|^2 and |o|*|v|
  logic [HalfW-1:0]        mlo;
  logic [HalfW-1:0]        mhi;
  logic [HalfW-1:0]        mul_a;
  logic [CoordW-1:0]       mul_b;
  logic [HalfW+CoordW-1:0] mul_p;
  logic [WideW-1:0]        mac_term;

  always_comb begin
    vt     = vel[axis] * $signed({1'b0, t});
    o_at_t = PosW'(off[axis]) + PosW'(vt >>> 16);
    vmag   = vel[axis][CoordW-1] ? CoordW'(-vel[axis]) : CoordW'(vel[axis]);
    ext_sel = which_box ? 3'(axis) + 3'd3 : 3'(axis);
    e_cur   = ext[ext_sel];
    e_sq    = e_cur * e_cur;
  end

  always_comb begin
    mlo   = pmag[axis][HalfW-1:0];
    mhi   = pmag[axis][MagW-1:HalfW];
    mul_a = mlo;
    mul_b = {{(CoordW-HalfW){1'b0}}, mlo};
    case (mphase)
      MP_LOLO: begin
        mul_a = mlo;
        mul_b = {{(CoordW-HalfW){1'b0}}, mlo};
      end
      MP_HILO: begin
        mul_a = mhi;
        mul_b = {{(CoordW-HalfW){1'b0}}, mlo};
      end
      MP_HIHI: begin
        mul_a = mhi;
        mul_b = {{(CoordW-HalfW){1'b0}}, mhi};
      end
      MP_LOV: begin
        mul_a = mlo;
        mul_b = vmag;
      end
      MP_HIV: begin
        mul_a = mhi;
        mul_b = vmag;
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
    // cross term counts twice in the square
    case (mphase)
      MP_HILO: mac_term = WideW'(mul_p) << (HalfW + 1);
      MP_HIHI: mac_term = WideW'(mul_p) << (2 * HalfW);
      MP_HIV:  mac_term = WideW'(mul_p) << HalfW;
      default: mac_term = WideW'(mul_p);
    endcase
  end

  // gap and increment
  logic signed [RootW+1:0] sep;
  logic [WideW-1:0]        dt_q;
  logic                    closing_pos;
  logic [TimeW:0]          t_left;

  always_comb begin
    sep         = $signed({2'b00, len}) - $signed({1'b0, comb});
    closing_pos = neg_acc > pos_acc;
    t_left      = {1'b0, time_step} - {1'b0, t};
    dt_q        = ures;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret_state <= S_IDLE;
      mphase    <= MP_LOLO;
      uctl      <= '0;
    end else begin
      uctl.start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            off[0] <= offset_x;  off[1] <= offset_y;  off[2] <= offset_z;
            vel[0] <= rel_vel_x; vel[1] <= rel_vel_y; vel[2] <= rel_vel_z;
            ext[0] <= extent_a_x; ext[1] <= extent_a_y; ext[2] <= extent_a_z;
            ext[3] <= extent_b_x; ext[4] <= extent_b_y; ext[5] <= extent_b_z;
            axis      <= 2'd0;
            which_box <= 1'b0;
            sq        <= '0;
            comb      <= '0;
            t         <= '0;
            iter      <= '0;
            state     <= S_RSQ;
          end
        end
        S_RSQ: begin
          sq <= sq + WideW'(e_sq);
          if (axis == 2'd2) begin
            axis      <= 2'd0;
            uopa      <= sq + WideW'(e_sq);
            uctl.op   <= OP_SQRT;
            uctl.start <= 1'b1;
            ret_state <= S_RROOT;
            state     <= S_START;
          end else begin
            axis <= axis + 2'd1;
          end
        end
        S_START: begin
          if (usts.busy) state <= ret_state;
        end
        S_RROOT: begin
          if (usts.done) begin
            comb <= comb + (RootW+1)'(ures[RootW-1:0]);
            sq   <= '0;
            if (which_box) begin
              state <= S_POS;
            end else begin
              which_box <= 1'b1;
              state     <= S_RSQ;
            end
          end
        end
        S_POS: begin
          pmag[axis] <= o_at_t[PosW-1] ? MagW'(-o_at_t) : MagW'(o_at_t);
          pneg[axis] <= o_at_t[PosW-1];
          if (axis == 2'd2) begin
            axis    <= 2'd0;
            mphase  <= MP_LOLO;
            sq      <= '0;
            pos_acc <= '0;
            neg_acc <= '0;
            state   <= S_MUL;
          end else begin
            axis <= axis + 2'd1;
          end
        end
        S_MUL: begin
          case (mphase)
            MP_LOLO: begin
              sq     <= sq + mac_term;
              mphase <= MP_HILO;
            end
            MP_HILO: begin
              sq     <= sq + mac_term;
              mphase <= MP_HIHI;
            end
            MP_HIHI: begin
              sq     <= sq + mac_term;
              mphase <= MP_LOV;
            end
            MP_LOV: begin
              if (pneg[axis] != vel[axis][CoordW-1]) neg_acc <= neg_acc + mac_term;
              else pos_acc <= pos_acc + mac_term;
              mphase <= MP_HIV;
            end
            default: begin
              // last product of this axis; the square sum is already complete
              if (pneg[axis] != vel[axis][CoordW-1]) neg_acc <= neg_acc + mac_term;
              else pos_acc <= pos_acc + mac_term;
              mphase <= MP_LOLO;
              if (axis == 2'd2) begin
                axis       <= 2'd0;
                uopa       <= sq;
                uctl.op    <= OP_SQRT;
                uctl.start <= 1'b1;
                ret_state  <= S_LROOT;
                state      <= S_START;
              end else begin
                axis <= axis + 2'd1;
              end
            end
          endcase
        end
        S_LROOT: begin
          if (usts.done) begin
            len   <= ures[RootW-1:0];
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (len == '0 || sep < $signed({{(RootW-TolW+2){1'b0}}, tolerance})) begin
            res_hit  <= 1'b1;
            res_time <= t;
            state    <= S_OUT;
          end else if (!closing_pos) begin
            res_hit  <= 1'b0;
            res_time <= time_step;
            state    <= S_OUT;
          end else begin
            uopa       <= neg_acc - pos_acc;
            uopb       <= WideW'(len);
            uctl.op    <= OP_DIV;
            uctl.start <= 1'b1;
            ret_state  <= S_CDIV;
            state      <= S_START;
          end
        end
        S_CDIV: begin
          if (usts.done) begin
            closing <= ures;
            state   <= S_CTEST;
          end
        end
        S_CTEST: begin
          if (closing <= WideW'(speed_eps)) begin
            res_hit  <= 1'b0;
            res_time <= time_step;
            state    <= S_OUT;
          end else begin
            // closing above 64 bits behaves as saturated; dividing by it
            // still floors to zero here as in the exact divide
            uopa       <= WideW'(sep[RootW-1:0]) << 16;
            uopb       <= closing;
            uctl.op    <= OP_DIV;
            uctl.start <= 1'b1;
            ret_state  <= S_TDIV;
            state      <= S_START;
          end
        end
        S_TDIV: begin
          if (usts.done) state <= S_TTEST;
        end
        S_TTEST: begin
          if (dt_q >= WideW'(t_left) || iter == IterW'(MaxIterations - 1)) begin
            res_hit  <= 1'b0;
            res_time <= time_step;
            state    <= S_OUT;
          end else begin
            t     <= t + dt_q[TimeW-1:0];
            iter  <= iter + 1'b1;
            axis  <= 2'd0;
            state <= S_POS;
          end
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready    = (state == S_IDLE);
  assign out_valid   = (state == S_OUT);
  assign hit         = res_hit;
  assign impact_time = res_time;

endmodule

[design/scat_checker.sv]
// ----------------------------------------------------------------------------
// scat_checker: port-level checks for the time-of-impact unit
// one result beat per input beat, bound to the top level
// ----------------------------------------------------------------------------
module scat_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        hit,
  input logic [scat_pkg::TimeW-1:0]  impact_time
);
  import scat_pkg::*;

  // never ready for a new beat while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready while result pending");

  // an accepted input is never answered in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");

  // result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(hit) && $stable(impact_time)))
    else $error("result changed under stall");

  // after a taken result the block is ready again
  a_back: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> in_ready) else $error("not ready after result");

endmodule

bind sphere_conservative_advancement_toi_unit scat_checker u_scat_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .hit         (hit),
  .impact_time (impact_time)
);

[verif/tb_sphere_conservative_advancement_toi_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sphere_conservative_advancement_toi_unit: self-checking bench for the toi unit
// directed table then random pairs of bodies, each result checked against its
// row's expectation or a bit-true time-of-impact predictor, under several register and idling settings
// ----------------------------------------------------------------------------
module tb_sphere_conservative_advancement_toi_unit;
  import scat_pkg::*;

  localparam int WatchdogLimit = 40000;   // quiet time allowed for the longest item plus the long hold
  localparam int HoldCycles    = 3000;
  localparam int PhaseItems    = 70;

  // one pair of bodies, components indexed x, y, z
  typedef struct packed {
    logic [2:0][CoordW-1:0] ofs;
    logic [2:0][CoordW-1:0] vel;
    logic [2:0][ExtW-1:0]   ext_a;
    logic [2:0][ExtW-1:0]   ext_b;
  } body_pair_t;

  typedef struct packed {
    logic             hit;
    logic [TimeW-1:0] tm;
  } impact_t;

  typedef struct packed {
    body_pair_t pair;
    logic       typed;   // expectation written in the row, not predicted
    impact_t    res;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CfgTimeStep;
  logic [CfgW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  body_pair_t cur_pair = '0;
  logic cur_typed = 1'b0;
  impact_t cur_res = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;
  logic [TimeW-1:0] impact_time;

  // bench copy of the registers
  logic [TimeW-1:0] step_span = TimeStepReset;
  logic [TolW-1:0]  contact_tol = ToleranceReset;
  logic [TolW-1:0]  min_closing = SpeedEpsReset;

  impact_t impact_q[$];
  int pairs_sent = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int mismatches = 0;
  int stall_pct = 0;
  int hold_go = 0;
  int quiet_cycles = 0;
  table_row_t dir_rows[13];

  sphere_conservative_advancement_toi_unit DUT (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready,
    .offset_x(cur_pair.ofs[0]), .offset_y(cur_pair.ofs[1]), .offset_z(cur_pair.ofs[2]),
    .rel_vel_x(cur_pair.vel[0]), .rel_vel_y(cur_pair.vel[1]), .rel_vel_z(cur_pair.vel[2]),
    .extent_a_x(cur_pair.ext_a[0]), .extent_a_y(cur_pair.ext_a[1]),
    .extent_a_z(cur_pair.ext_a[2]),
    .extent_b_x(cur_pair.ext_b[0]), .extent_b_y(cur_pair.ext_b[1]),
    .extent_b_z(cur_pair.ext_b[2]),
    .out_valid, .out_ready, .hit, .impact_time
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // floor square root, result below 2^50
  function automatic logic [63:0] isqrt(input logic [127:0] n);
    logic [63:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 49; b >= 0; b--) begin
      c = {64'd0, r | (64'd1 << b)};
      if (c * c <= n) r = c[63:0];
    end
    return r;
  endfunction

  // bounding sphere radius of one box
  function automatic logic [63:0] sphere_radius(input logic [2:0][ExtW-1:0] e);
    logic [127:0] s;
    s = '0;
    for (int k = 0; k < 3; k++) s += {97'd0, e[k]} * {97'd0, e[k]};
    return isqrt(s);
  endfunction

  // conservative advancement of the pair with the current registers
  function automatic impact_t advance_to_impact(input body_pair_t p);
    impact_t r;
    logic [63:0] comb, t, len, closing, gap, dt, span;
    logic signed [127:0] sq, dot, os, vs, q;
    longint o, v, sep;
    comb = sphere_radius(p.ext_a) + sphere_radius(p.ext_b);
    span = {33'd0, step_span};
    t = '0;
    r.hit = 1'b0;
    r.tm = step_span;
    for (int i = 0; i < MaxIterations; i++) begin
      sq = '0;
      dot = '0;
      for (int k = 0; k < 3; k++) begin
        v = longint'($signed(p.vel[k]));
        o = longint'($signed(p.ofs[k])) + ((v * longint'(t)) >>> 16);
        os = 128'(o);
        vs = 128'(v);
        sq += os * os;
        dot += os * vs;
      end
      len = isqrt(sq);
      sep = longint'(len) - longint'(comb);
      // touching or coincident centres
      if (len == 0 || sep < longint'({48'd0, contact_tol})) begin
        r.hit = 1'b1;
        r.tm = t[TimeW-1:0];
        return r;
      end
      if (dot >= 0) return r;   // opening or not moving
      q = (-dot) / $signed({64'd0, len});
      closing = (q[127:64] != 0) ? '1 : q[63:0];
      if (closing <= {48'd0, min_closing}) return r;
      gap = sep;
      dt = (gap << 16) / closing;
      if (dt >= span - t) return r;
      t += dt;
    end
    return r;
  endfunction

  // scoreboard: predict on input beats, compare on output beats
  always @(posedge clk) begin
    impact_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (cur_typed) impact_q.push_back(cur_res);
        else impact_q.push_back(advance_to_impact(cur_pair));
      end
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (hit) hits_seen <= hits_seen + 1;
        if (impact_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat hit=%0b t=%0d", hit, impact_time);
        end else begin
          want = impact_q.pop_front();
          if (want.hit !== hit || want.tm !== impact_time) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected hit=%0b t=%0d, got hit=%0b t=%0d",
                       want.hit, want.tm, hit, impact_time);
          end
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no beat for %0d cycles", WatchdogLimit);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stalls, plus a long hold on request
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_go != hold_seen) begin
        hold_seen = hold_go;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgTimeStep:  step_span = val[TimeW-1:0];
      CfgTolerance: contact_tol = val[TolW-1:0];
      CfgSpeedEps:  min_closing = val[TolW-1:0];
      default: ;
    endcase
  endtask

  // one input beat; valid stays high on return unless the next call idles
  task automatic send_pair(input body_pair_t p, input logic typed, input impact_t r,
                           input int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cur_pair <= p;
    cur_typed <= typed;
    cur_res <= r;
    do @(posedge clk); while (!in_ready);
    pairs_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (results_seen != pairs_sent) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // mostly approaching bodies with random content, some pure noise
  function automatic body_pair_t random_pair;
    body_pair_t p;
    longint o, v;
    int f;
    f = $urandom_range(1, 64);
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(3) == 0) begin
        p.ofs[k] = $urandom();
        p.vel[k] = $urandom();
        p.ext_a[k] = ExtW'($urandom());
        p.ext_b[k] = ExtW'($urandom());
      end else begin
        o = longint'($urandom_range(0, 32'h0040_0000)) - 64'sh20_0000;
        v = -((o * f) >>> 4) + longint'($urandom_range(0, 32'h8000)) - 64'sh4000;
        p.ofs[k] = o[31:0];
        p.vel[k] = v[31:0];
        p.ext_a[k] = ExtW'($urandom_range(0, 32'h0004_0000));
        p.ext_b[k] = ExtW'($urandom_range(0, 32'h0004_0000));
      end
    end
    return p;
  endfunction

  function automatic table_row_t make_row(input body_pair_t p, input logic typed,
                                          input logic h, input logic [TimeW-1:0] tm);
    table_row_t row;
    row.pair = p;
    row.typed = typed;
    row.res.hit = h;
    row.res.tm = tm;
    return row;
  endfunction

  initial begin
    body_pair_t p;
    logic [CfgW-1:0] spans[4];
    logic [TolW-1:0] tols[4];
    logic [TolW-1:0] epss[4];
    int sender_idle[4];
    int recv_stall[4];
    spans = '{31'd65536, 31'h7FFF_FFFF, 31'd1, 31'd32768};
    tols = '{16'd66, 16'd0, 16'hFFFF, 16'd655};
    epss = '{16'd1, 16'd0, 16'hFFFF, 16'd16};
    sender_idle = '{0, 75, 0, 34};
    recv_stall = '{0, 0, 75, 34};

    // directed rows, run with the registers at their reset values
    p = '0;
    dir_rows[0] = make_row(p, 1'b1, 1'b1, '0);           // coincident centres
    p.ofs[0] = 32'd6553600;
    dir_rows[1] = make_row(p, 1'b1, 1'b0, TimeStepReset); // at rest, far apart
    p.ofs[0] = 32'd655360;
    p.vel[0] = 32'd65536;
    dir_rows[2] = make_row(p, 1'b1, 1'b0, TimeStepReset); // moving apart
    p = '0;
    p.ofs[0] = 32'd65536;
    p.ext_a[0] = 31'd131072;
    dir_rows[3] = make_row(p, 1'b1, 1'b1, '0);           // already overlapping
    p = '0;
    p.ofs[0] = 32'd65536;
    p.vel[0] = 32'hFFFF_FFFF;
    dir_rows[4] = make_row(p, 1'b1, 1'b0, TimeStepReset); // closing at epsilon
    p.ofs = '{3{32'h8000_0000}};
    p.vel = '{3{32'h7FFF_FFFF}};
    p.ext_a = '{3{31'h7FFF_FFFF}};
    p.ext_b = '{3{31'h7FFF_FFFF}};
    dir_rows[5] = make_row(p, 1'b0, 1'b0, '0);           // extremes, closing
    p.ofs = '{3{32'h7FFF_FFFF}};
    p.vel = '{3{32'h8000_0000}};
    p.ext_a = '0;
    p.ext_b = '0;
    dir_rows[6] = make_row(p, 1'b0, 1'b0, '0);
    p.vel = '{3{32'h7FFF_FFFF}};
    dir_rows[7] = make_row(p, 1'b1, 1'b0, TimeStepReset); // extremes, opening
    p = '0;
    p.ofs[0] = 32'd655360;
    p.vel[0] = -32'sd65536000;
    dir_rows[8] = make_row(p, 1'b0, 1'b0, '0);           // fast head-on
    p = '0;
    p.ofs[1] = -32'sd327680;
    p.vel[1] = 32'sd131072000;
    p.ext_b = '{3{31'd32768}};
    dir_rows[9] = make_row(p, 1'b0, 1'b0, '0);
    p = '0;
    p.ext_a = '{3{31'h7FFF_FFFF}};
    p.ext_b = '{3{31'h7FFF_FFFF}};
    dir_rows[10] = make_row(p, 1'b1, 1'b1, '0);          // huge boxes, same centre
    p.ofs = '{3{32'hAAAA_AAAA}};
    p.vel = '{3{32'h5555_5555}};
    p.ext_a = '{3{31'h2AAA_AAAA}};
    p.ext_b = '{3{31'h5555_5555}};
    dir_rows[11] = make_row(p, 1'b0, 1'b0, '0);
    p.ofs = '{3{32'h5555_5555}};
    p.vel = '{3{32'hAAAA_AAAA}};
    dir_rows[12] = make_row(p, 1'b0, 1'b0, '0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_pair(dir_rows[i].pair, dir_rows[i].typed, dir_rows[i].res, 0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CfgTimeStep, spans[ph]);
      write_reg(CfgTolerance, {15'd0, tols[ph]});
      write_reg(CfgSpeedEps, {15'd0, epss[ph]});
      stall_pct = recv_stall[ph];
      // long receiver hold while inputs keep coming, so the input stalls
      if (ph == 3) hold_go++;
      for (int n = 0; n < PhaseItems; n++)
        send_pair(random_pair(), 1'b0, '0, sender_idle[ph]);
      drain();
    end

    $display("covered %0d pairs (%0d hits) over four register settings and idling modes",
             pairs_sent, hits_seen);
    $display("%0d results checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && impact_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[files.f]
design/scat_pkg.sv
design/scat_unit.sv
design/sphere_conservative_advancement_toi_unit.sv
design/scat_checker.sv
verif/tb_sphere_conservative_advancement_toi_unit.sv
